// File: design/frx_pkg.sv
// Package for the Fresnel refraction unit: beat types, side-band structs,
// reset constants, the rounding helper and the magnitude helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package frx_pkg;

  localparam int unsigned ETA_W   = 21;
  localparam int unsigned RAD_W   = 44;
  localparam int unsigned ROOT_W  = 22;
  localparam int unsigned MAG_W   = 36;
  localparam int unsigned Q_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [ETA_W-1:0] ETA_CAP       = 21'h100000;
  localparam logic [ETA_W-1:0] ETA_ENTER_RST = 21'd43691;
  localparam logic [ETA_W-1:0] ETA_EXIT_RST  = 21'd98304;
  localparam logic [15:0] OUTSIDE_RST = 16'd16384;
  localparam logic [15:0] INSIDE_RST  = 16'd24576;
  localparam logic [14:0] REFL_ONE    = 15'd16384;
  localparam logic [Q_W-1:0] COEF_ONE = 16'd16384;
  localparam logic [Q_W-1:0] COEF_CAP = 16'd65535;

  localparam logic [CFG_IDX_W-1:0] REG_OUTSIDE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INSIDE  = 8'd1;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] facing_x;
    logic signed [15:0] facing_y;
    logic signed [15:0] facing_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic [14:0]        reflectance;
    logic signed [15:0] trans_x;
    logic signed [15:0] trans_y;
    logic signed [15:0] trans_z;
    logic               total_reflection;
  } out_item_t;

  typedef struct packed {
    logic               tir;
    logic [15:0]        n1;
    logic [15:0]        n2;
    logic signed [18:0] c;
    logic signed [23:0] ecr;
    logic signed [15:0] fac_x;
    logic signed [15:0] fac_y;
    logic signed [15:0] fac_z;
    logic signed [21:0] edr_x;
    logic signed [21:0] edr_y;
    logic signed [21:0] edr_z;
  } sq_side_t;

  typedef struct packed {
    logic               tir;
    logic signed [15:0] tr_x;
    logic signed [15:0] tr_y;
    logic signed [15:0] tr_z;
  } cd_side_t;

  // Shift right by s (s >= 1), rounding half away from zero.
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned s);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [MAG_W-1:0] mag37(input logic signed [36:0] v);
    logic [36:0] a;
    a = v[36] ? 37'(-v) : 37'(v);
    return a[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: design/fresnel_refraction_unit_core.sv
// A beat passes the front, square root, back, coefficient divider and square
// and output stages. Throughput: one beat per cycle while no index recompute runs;
// the whole pipeline holds while the output beat is not taken. A register write
// recomputes both relative indices in two iterative dividers; input ready stays
// low until both new ratios are stored. Reset restores the index registers and
// their precomputed ratios; no item is held over reset.
`timescale 1ns / 1ps
`default_nettype none

module fresnel_refraction_unit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  frx_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output frx_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [frx_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  logic en, cfg_fire, cfg_busy;
  logic [15:0] outside_q, inside_q;
  logic pend_q;
  logic busy_e, busy_x, done_e, done_x;
  logic [frx_pkg::ETA_W-1:0] eta_e, eta_x, eta_enter_q, eta_exit_q;

  logic                       f_valid;
  logic [frx_pkg::RAD_W-1:0]  f_rad;
  frx_pkg::sq_side_t          f_side;
  logic                       s_valid;
  logic [frx_pkg::ROOT_W-1:0] s_root;
  frx_pkg::sq_side_t          s_side;
  logic                       b_valid;
  logic [frx_pkg::MAG_W-1:0]  b_ns, b_ds, b_np, b_dp;
  frx_pkg::cd_side_t          b_side;
  logic                       d_valid;
  logic [frx_pkg::Q_W-1:0]    d_qs, d_qp;
  frx_pkg::cd_side_t          d_side;

  logic                       sq_valid_q;
  logic [31:0]                sqs_q, sqp_q;
  frx_pkg::cd_side_t          sq_side_q;
  logic [32:0]                sum_d;
  logic [14:0]                refl_d;
  logic                       out_valid_q;
  frx_pkg::out_item_t         out_data_q;

  assign en          = !out_valid_q || out_ready_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_busy    = pend_q || busy_e || busy_x || done_e || done_x;
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = en && !cfg_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outside_q   <= frx_pkg::OUTSIDE_RST;
      inside_q    <= frx_pkg::INSIDE_RST;
      pend_q      <= 1'b0;
      eta_enter_q <= frx_pkg::ETA_ENTER_RST;
      eta_exit_q  <= frx_pkg::ETA_EXIT_RST;
    end else begin
      pend_q <= cfg_fire;
      if (cfg_fire) begin
        if (cfg_index_i == frx_pkg::REG_OUTSIDE) begin
          outside_q <= cfg_data_i;
        end else if (cfg_index_i == frx_pkg::REG_INSIDE) begin
          inside_q <= cfg_data_i;
        end
      end
      if (done_e) begin
        eta_enter_q <= eta_e;
      end
      if (done_x) begin
        eta_exit_q <= eta_x;
      end
    end
  end

  frx_eta_div u_eta_enter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pend_q),
    .num_i   (outside_q),
    .den_i   (inside_q),
    .busy_o  (busy_e),
    .done_o  (done_e),
    .eta_o   (eta_e)
  );

  frx_eta_div u_eta_exit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pend_q),
    .num_i   (inside_q),
    .den_i   (outside_q),
    .busy_o  (busy_x),
    .done_o  (done_x),
    .eta_o   (eta_x)
  );

  frx_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (in_valid_i && in_ready_o),
    .data_i          (in_data_i),
    .eta_enter_i     (eta_enter_q),
    .eta_exit_i      (eta_exit_q),
    .outside_index_i (outside_q),
    .inside_index_i  (inside_q),
    .valid_o         (f_valid),
    .rad_o           (f_rad),
    .side_o          (f_side)
  );

  frx_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .rad_i   (f_rad),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  frx_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .root_i  (s_root),
    .side_i  (s_side),
    .valid_o (b_valid),
    .num_s_o (b_ns),
    .den_s_o (b_ds),
    .num_p_o (b_np),
    .den_p_o (b_dp),
    .side_o  (b_side)
  );

  frx_coef_div u_coef_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_valid),
    .num_s_i (b_ns),
    .den_s_i (b_ds),
    .num_p_i (b_np),
    .den_p_i (b_dp),
    .side_i  (b_side),
    .valid_o (d_valid),
    .q_s_o   (d_qs),
    .q_p_o   (d_qp),
    .side_o  (d_side)
  );

  assign sum_d  = 33'(sqs_q) + 33'(sqp_q) + 33'h4000;
  assign refl_d = (sq_side_q.tir || sum_d[32:15] > 18'(frx_pkg::REFL_ONE))
                ? frx_pkg::REFL_ONE : sum_d[29:15];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      sq_valid_q  <= d_valid;
      out_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqs_q     <= 32'(d_qs) * 32'(d_qs);
      sqp_q     <= 32'(d_qp) * 32'(d_qp);
      sq_side_q <= d_side;
      out_data_q.reflectance      <= refl_d;
      out_data_q.trans_x          <= sq_side_q.tr_x;
      out_data_q.trans_y          <= sq_side_q.tr_y;
      out_data_q.trans_z          <= sq_side_q.tr_z;
      out_data_q.total_reflection <= sq_side_q.tir;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("input taken right after a register write");

  a_tir_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.total_reflection |->
      out_data_o.trans_x == 16'sd0 && out_data_o.trans_y == 16'sd0 &&
      out_data_o.trans_z == 16'sd0 && out_data_o.reflectance == frx_pkg::REFL_ONE)
    else $error("total reflection beat with nonzero direction or reflectance");

  a_refl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.reflectance <= frx_pkg::REFL_ONE)
    else $error("reflectance above one");
`endif

endmodule

`default_nettype wire

// File: design/frx_eta_div.sv
// Iterative restoring divider for the relative index, one quotient bit per cycle.
// Uses frx_pkg for widths and the saturation cap.
`timescale 1ns / 1ps
`default_nettype none

module frx_eta_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [15:0]              num_i,
  input  logic [15:0]              den_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [frx_pkg::ETA_W-1:0] eta_o
);

  localparam logic [4:0] LAST_CNT = 5'd31;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] dvd_q, quo_q;
  logic [15:0] rem_q, den_q;
  logic [15:0] dv;
  logic [16:0] trial;
  logic        ge;

  assign dv    = (den_i == 16'd0) ? 16'd1 : den_i;
  assign trial = {rem_q, dvd_q[31]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST_CNT);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LAST_CNT) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_i, 16'd0} + 32'(dv >> 1);
      quo_q <= '0;
      rem_q <= '0;
      den_q <= dv;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[30:0], ge};
      rem_q <= ge ? 16'(trial - {1'b0, den_q}) : trial[15:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign eta_o  = (quo_q > 32'(frx_pkg::ETA_CAP)) ? frx_pkg::ETA_CAP
                                                   : quo_q[frx_pkg::ETA_W-1:0];

endmodule

`default_nettype wire

// File: design/frx_front.sv
// Front pipeline: side select, cosine, eta squared and refraction radicand.
// Six register stages; uses frx_pkg types and rounding.
`timescale 1ns / 1ps
`default_nettype none

module frx_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  frx_pkg::in_item_t         data_i,
  input  logic [frx_pkg::ETA_W-1:0] eta_enter_i,
  input  logic [frx_pkg::ETA_W-1:0] eta_exit_i,
  input  logic [15:0]               outside_index_i,
  input  logic [15:0]               inside_index_i,
  output logic                      valid_o,
  output logic [frx_pkg::RAD_W-1:0] rad_o,
  output frx_pkg::sq_side_t         side_o
);

  logic [5:0] vld_q;

  // stage 1
  logic signed [32:0] dn_d, fd_d, fd1_q;
  logic               enter1_q;
  logic signed [15:0] fac1_q [3];
  logic signed [15:0] dir1_q [3];
  // stage 2
  logic [frx_pkg::ETA_W-1:0] eta2_q;
  logic [15:0]        n1_2_q, n2_2_q;
  logic signed [18:0] c2_q;
  logic signed [15:0] fac2_q [3];
  logic signed [15:0] dir2_q [3];
  logic signed [63:0] c_r;
  // stage 3
  logic signed [37:0] csq3_q;
  logic [41:0]        esq3_q;
  logic signed [40:0] etac3_q;
  logic signed [37:0] ed3_q [3];
  logic [15:0]        n1_3_q, n2_3_q;
  logic signed [18:0] c3_q;
  logic signed [15:0] fac3_q [3];
  logic signed [21:0] eta_s;
  // stage 4
  logic signed [23:0] s14_4_q;
  logic [24:0]        etasq4_q;
  logic [41:0]        esq_rnd;
  logic signed [63:0] s14_r, ecr_r;
  logic signed [63:0] edr_r [3];
  frx_pkg::sq_side_t  side4_d, side4_q, side5_q;
  // stage 5
  logic signed [49:0] p5_q;
  // stage 6
  logic signed [63:0] k_d, p_r;
  logic [frx_pkg::RAD_W-1:0] rad_q;
  frx_pkg::sq_side_t  side6_d, side6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign dn_d = 33'(32'(data_i.dir_x) * 32'(data_i.normal_x))
              + 33'(32'(data_i.dir_y) * 32'(data_i.normal_y))
              + 33'(32'(data_i.dir_z) * 32'(data_i.normal_z));
  assign fd_d = 33'(32'(data_i.facing_x) * 32'(data_i.dir_x))
              + 33'(32'(data_i.facing_y) * 32'(data_i.dir_y))
              + 33'(32'(data_i.facing_z) * 32'(data_i.dir_z));

  assign c_r     = frx_pkg::rnd_sh(64'(fd1_q), 14);
  assign eta_s   = $signed({1'b0, eta2_q});
  assign esq_rnd = esq3_q + 42'h8000;
  assign s14_r   = frx_pkg::rnd_sh(64'sd268435456 - 64'(csq3_q), 14);
  assign ecr_r   = frx_pkg::rnd_sh(64'(etac3_q), 16);
  assign p_r     = frx_pkg::rnd_sh(64'(p5_q), 2);
  assign k_d     = 64'sd268435456 - p_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      edr_r[i] = frx_pkg::rnd_sh(64'(ed3_q[i]), 16);
    end
    side4_d       = '0;
    side4_d.n1    = n1_3_q;
    side4_d.n2    = n2_3_q;
    side4_d.c     = c3_q;
    side4_d.ecr   = ecr_r[23:0];
    side4_d.fac_x = fac3_q[0];
    side4_d.fac_y = fac3_q[1];
    side4_d.fac_z = fac3_q[2];
    side4_d.edr_x = edr_r[0][21:0];
    side4_d.edr_y = edr_r[1][21:0];
    side4_d.edr_z = edr_r[2][21:0];
    side6_d       = side5_q;
    side6_d.tir   = k_d[63];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      enter1_q  <= dn_d[32];
      fd1_q     <= fd_d;
      fac1_q[0] <= data_i.facing_x;
      fac1_q[1] <= data_i.facing_y;
      fac1_q[2] <= data_i.facing_z;
      dir1_q[0] <= data_i.dir_x;
      dir1_q[1] <= data_i.dir_y;
      dir1_q[2] <= data_i.dir_z;

      eta2_q <= enter1_q ? eta_enter_i : eta_exit_i;
      n1_2_q <= enter1_q ? outside_index_i : inside_index_i;
      n2_2_q <= enter1_q ? inside_index_i : outside_index_i;
      c2_q   <= c_r[18:0];
      fac2_q <= fac1_q;
      dir2_q <= dir1_q;

      csq3_q  <= 38'(c2_q) * 38'(c2_q);
      esq3_q  <= 42'(eta2_q) * 42'(eta2_q);
      etac3_q <= 41'(eta_s) * 41'(c2_q);
      for (int i = 0; i < 3; i++) begin
        ed3_q[i] <= 38'(eta_s) * 38'(dir2_q[i]);
      end
      n1_3_q <= n1_2_q;
      n2_3_q <= n2_2_q;
      c3_q   <= c2_q;
      fac3_q <= fac2_q;

      s14_4_q  <= s14_r[23:0];
      etasq4_q <= esq_rnd[40:16];
      side4_q  <= side4_d;

      p5_q    <= 50'($signed({1'b0, etasq4_q})) * 50'(s14_4_q);
      side5_q <= side4_q;

      rad_q   <= k_d[frx_pkg::RAD_W-1:0];
      side6_q <= side6_d;
    end
  end

  assign valid_o = vld_q[5];
  assign rad_o   = rad_q;
  assign side_o  = side6_q;

endmodule

`default_nettype wire

// File: design/frx_isqrt.sv
// Pipelined floor square root, one root bit per register stage.
// Carries the refraction side band alongside; uses frx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frx_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [frx_pkg::RAD_W-1:0]  rad_i,
  input  frx_pkg::sq_side_t          side_i,
  output logic                       valid_o,
  output logic [frx_pkg::ROOT_W-1:0] root_o,
  output frx_pkg::sq_side_t          side_o
);

  localparam int unsigned NST = frx_pkg::ROOT_W;
  localparam int unsigned VW  = frx_pkg::RAD_W;
  localparam int unsigned RW  = frx_pkg::RAD_W + 1;

  logic [NST-1:0]    vld_q;
  logic [VW-1:0]     v_q    [NST];
  logic [RW-1:0]     r_q    [NST];
  frx_pkg::sq_side_t side_q [NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  for (genvar j = 0; j < NST; j++) begin : g_st
    localparam int unsigned SH = 2 * (NST - 1 - j);
    logic [VW-1:0]     v_in;
    logic [RW-1:0]     r_in, bitv, trial;
    frx_pkg::sq_side_t s_in;
    logic              ge;

    if (j == 0) begin : g_first
      assign v_in = rad_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[j-1];
      assign r_in = r_q[j-1];
      assign s_in = side_q[j-1];
    end

    assign bitv  = RW'(1) << SH;
    assign trial = r_in + bitv;
    assign ge    = {1'b0, v_in} >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[j]    <= ge ? VW'({1'b0, v_in} - trial) : v_in;
        r_q[j]    <= ge ? (r_in >> 1) + bitv : r_in >> 1;
        side_q[j] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign root_o  = r_q[NST-1][frx_pkg::ROOT_W-1:0];
  assign side_o  = side_q[NST-1];

endmodule

`default_nettype wire

// File: design/frx_back.sv
// Back pipeline: refracted direction, transmitted cosine and the Fresnel
// numerators and denominators. Seven register stages; uses frx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frx_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [frx_pkg::ROOT_W-1:0] root_i,
  input  frx_pkg::sq_side_t          side_i,
  output logic                       valid_o,
  output logic [frx_pkg::MAG_W-1:0]  num_s_o,
  output logic [frx_pkg::MAG_W-1:0]  den_s_o,
  output logic [frx_pkg::MAG_W-1:0]  num_p_o,
  output logic [frx_pkg::MAG_W-1:0]  den_p_o,
  output frx_pkg::cd_side_t          side_o
);

  logic [6:0] vld_q;

  // stage 7
  logic signed [24:0] coef7_q;
  frx_pkg::sq_side_t  s7_q;
  // stage 8
  logic signed [40:0] cf8_q [3];
  logic signed [21:0] edr8 [3];
  frx_pkg::sq_side_t  s8_q;
  // stage 9
  logic signed [63:0] t9 [3];
  logic signed [15:0] tr9_d [3];
  logic signed [15:0] tr9_q [3];
  logic signed [15:0] fac9_q [3];
  logic               tir9_q;
  logic [15:0]        n1_9_q, n2_9_q;
  logic signed [18:0] c9_q;
  // stage 10
  logic signed [33:0] ft10_q;
  logic signed [15:0] tr10_q [3];
  logic               tir10_q;
  logic [15:0]        n1_10_q, n2_10_q;
  logic signed [18:0] c10_q;
  // stage 11
  logic signed [63:0] cost_r;
  logic signed [17:0] cost11_q;
  logic signed [15:0] tr11_q [3];
  logic               tir11_q;
  logic [15:0]        n1_11_q, n2_11_q;
  logic signed [18:0] c11_q;
  // stage 12
  logic signed [36:0] m1c_q, m2t_q, m2c_q, m1t_q;
  logic signed [15:0] tr12_q [3];
  logic               tir12_q;
  // stage 13
  logic [frx_pkg::MAG_W-1:0] ns_q, ds_q, np_q, dp_q;
  frx_pkg::cd_side_t  side13_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  assign edr8[0] = s8_q.edr_x;
  assign edr8[1] = s8_q.edr_y;
  assign edr8[2] = s8_q.edr_z;
  assign cost_r  = frx_pkg::rnd_sh(64'(ft10_q), 14);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t9[i] = 64'(edr8[i]) - frx_pkg::rnd_sh(64'(cf8_q[i]), 14);
      if (s8_q.tir) begin
        tr9_d[i] = '0;
      end else if (t9[i] > 64'sd16384) begin
        tr9_d[i] = 16'sd16384;
      end else if (t9[i] < -64'sd16384) begin
        tr9_d[i] = -16'sd16384;
      end else begin
        tr9_d[i] = t9[i][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coef7_q <= 25'(side_i.ecr) + $signed({3'd0, root_i});
      s7_q    <= side_i;

      cf8_q[0] <= 41'(coef7_q) * 41'(s7_q.fac_x);
      cf8_q[1] <= 41'(coef7_q) * 41'(s7_q.fac_y);
      cf8_q[2] <= 41'(coef7_q) * 41'(s7_q.fac_z);
      s8_q     <= s7_q;

      tr9_q     <= tr9_d;
      fac9_q[0] <= s8_q.fac_x;
      fac9_q[1] <= s8_q.fac_y;
      fac9_q[2] <= s8_q.fac_z;
      tir9_q    <= s8_q.tir;
      n1_9_q    <= s8_q.n1;
      n2_9_q    <= s8_q.n2;
      c9_q      <= s8_q.c;

      ft10_q  <= 34'(32'(fac9_q[0]) * 32'(tr9_q[0]))
               + 34'(32'(fac9_q[1]) * 32'(tr9_q[1]))
               + 34'(32'(fac9_q[2]) * 32'(tr9_q[2]));
      tr10_q  <= tr9_q;
      tir10_q <= tir9_q;
      n1_10_q <= n1_9_q;
      n2_10_q <= n2_9_q;
      c10_q   <= c9_q;

      cost11_q <= cost_r[17:0];
      tr11_q   <= tr10_q;
      tir11_q  <= tir10_q;
      n1_11_q  <= n1_10_q;
      n2_11_q  <= n2_10_q;
      c11_q    <= c10_q;

      m1c_q   <= 37'($signed({1'b0, n1_11_q})) * 37'(c11_q);
      m2t_q   <= 37'($signed({1'b0, n2_11_q})) * 37'(cost11_q);
      m2c_q   <= 37'($signed({1'b0, n2_11_q})) * 37'(c11_q);
      m1t_q   <= 37'($signed({1'b0, n1_11_q})) * 37'(cost11_q);
      tr12_q  <= tr11_q;
      tir12_q <= tir11_q;

      ns_q          <= frx_pkg::mag37(m1c_q - m2t_q);
      ds_q          <= frx_pkg::mag37(m1c_q + m2t_q);
      np_q          <= frx_pkg::mag37(m2c_q - m1t_q);
      dp_q          <= frx_pkg::mag37(m2c_q + m1t_q);
      side13_q.tir  <= tir12_q;
      side13_q.tr_x <= tr12_q[0];
      side13_q.tr_y <= tr12_q[1];
      side13_q.tr_z <= tr12_q[2];
    end
  end

  assign valid_o = vld_q[6];
  assign num_s_o = ns_q;
  assign den_s_o = ds_q;
  assign num_p_o = np_q;
  assign den_p_o = dp_q;
  assign side_o  = side13_q;

endmodule

`default_nettype wire

// File: design/frx_coef_div.sv
// Two-lane pipelined restoring divider for the Fresnel coefficient magnitudes,
// Q.14 quotient saturated to 16 bits. One check stage plus one stage per bit.
`timescale 1ns / 1ps
`default_nettype none

module frx_coef_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [frx_pkg::MAG_W-1:0] num_s_i,
  input  logic [frx_pkg::MAG_W-1:0] den_s_i,
  input  logic [frx_pkg::MAG_W-1:0] num_p_i,
  input  logic [frx_pkg::MAG_W-1:0] den_p_i,
  input  frx_pkg::cd_side_t         side_i,
  output logic                      valid_o,
  output logic [frx_pkg::Q_W-1:0]   q_s_o,
  output logic [frx_pkg::Q_W-1:0]   q_p_o,
  output frx_pkg::cd_side_t         side_o
);

  localparam int unsigned QW  = frx_pkg::Q_W;
  localparam int unsigned DW  = frx_pkg::MAG_W;
  localparam int unsigned RMW = frx_pkg::MAG_W + 14;
  localparam int unsigned TW  = RMW + 2;
  localparam int unsigned NST = QW + 1;

  logic [NST-1:0]    vld_q;
  logic [RMW-1:0]    rem_q  [2][NST];
  logic [DW-1:0]     den_q  [2][NST];
  logic [QW-1:0]     quo_q  [2][NST];
  logic              sat_q  [2][NST];
  logic              zero_q [2][NST];
  frx_pkg::cd_side_t side_q [NST];
  logic [DW-1:0]     num_in [2];
  logic [DW-1:0]     den_in [2];
  logic [QW-1:0]     q_out  [2];

  assign num_in[0] = num_s_i;
  assign den_in[0] = den_s_i;
  assign num_in[1] = num_p_i;
  assign den_in[1] = den_p_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < NST; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[l][0]  <= {num_in[l], 14'd0};
        den_q[l][0]  <= den_in[l];
        quo_q[l][0]  <= '0;
        sat_q[l][0]  <= {2'd0, num_in[l]} >= {den_in[l], 2'd0};
        zero_q[l][0] <= den_in[l] == '0;
      end
    end

    for (genvar s = 1; s < NST; s++) begin : g_st
      localparam int unsigned BI = QW - s;
      logic [TW-1:0] trial;
      logic          ge;

      assign trial = TW'(den_q[l][s-1]) << BI;
      assign ge    = TW'(rem_q[l][s-1]) >= trial;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[l][s]  <= ge ? RMW'(TW'(rem_q[l][s-1]) - trial) : rem_q[l][s-1];
          den_q[l][s]  <= den_q[l][s-1];
          quo_q[l][s]  <= quo_q[l][s-1] | (QW'(ge) << BI);
          sat_q[l][s]  <= sat_q[l][s-1];
          zero_q[l][s] <= zero_q[l][s-1];
        end
      end
    end

    assign q_out[l] = zero_q[l][NST-1] ? frx_pkg::COEF_ONE :
                      sat_q[l][NST-1]  ? frx_pkg::COEF_CAP : quo_q[l][NST-1];
  end

  assign valid_o = vld_q[NST-1];
  assign q_s_o   = q_out[0];
  assign q_p_o   = q_out[1];
  assign side_o  = side_q[NST-1];

endmodule

`default_nettype wire
